// ===== rtl/core/pdh_pkg.sv =====
`default_nettype none
package pdh_pkg;
    localparam int MAX_ATOMS_A = 1024;
    localparam int MAX_ATOMS_B = 1024;
    localparam int NUM_BINS = 64;
    localparam int AW = $clog2(MAX_ATOMS_A);
    localparam int BW = $clog2(MAX_ATOMS_B);
    localparam int CAW = $clog2(MAX_ATOMS_A + 1);
    localparam int CBW = $clog2(MAX_ATOMS_B + 1);
    localparam int HW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CW = 18;
    localparam int LW = 17;
    localparam int SQW = 38;   // sum of three 18 bit squares
    localparam int RW = 19;    // root width
    localparam int SQRT_STEPS = RW;
    localparam logic [20:0] COUNT_MAX = 21'd1048576;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_END    = 2'd2;

    localparam logic [2:0] REG_BOX_X = 3'd0;
    localparam logic [2:0] REG_BOX_Y = 3'd1;
    localparam logic [2:0] REG_BOX_Z = 3'd2;
    localparam logic [2:0] REG_BIN_W = 3'd3;
    localparam logic [2:0] REG_CUTOFF = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAIRS, ST_DRAIN, ST_REPORT
    } state_t;

    typedef struct packed {
        logic          valid;
        logic [RW-1:0] rem;    // remaining value, shrinks per bin cell
        logic [HW-1:0] bin;
        logic          in_range;
    } bin_tok_t;
endpackage
`default_nettype wire

// ===== rtl/core/pdh_sqrt_cell.sv =====
`default_nettype none
// one restoring square-root step
module pdh_sqrt_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [pdh_pkg::SQW-1:0]   in_v,
    input  wire logic [pdh_pkg::RW-1:0]    in_root,
    input  wire logic [pdh_pkg::SQW+1:0]   in_rem,
    output logic                           out_valid,
    output logic [pdh_pkg::SQW-1:0]        out_v,
    output logic [pdh_pkg::RW-1:0]         out_root,
    output logic [pdh_pkg::SQW+1:0]        out_rem
);
    logic [pdh_pkg::SQW+1:0] shifted;
    logic [pdh_pkg::SQW+1:0] trial;
    logic [pdh_pkg::SQW+1:0] diff;
    always_comb
    begin
        shifted = {in_rem[pdh_pkg::SQW-1:0], in_v[pdh_pkg::SQW-1 -: 2]};
        trial = {{(pdh_pkg::SQW+2-pdh_pkg::RW-2){1'b0}}, in_root, 2'b01};
        diff = shifted - trial;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        out_v <= {in_v[pdh_pkg::SQW-3:0], 2'b00};
        if (shifted >= trial)
        begin
            out_rem <= diff;
            out_root <= {in_root[pdh_pkg::RW-2:0], 1'b1};
        end
        else
        begin
            out_rem <= shifted;
            out_root <= {in_root[pdh_pkg::RW-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pdh_bin_cell.sv =====
`default_nettype none
// one histogram bin: checks its range, counts, hands remainder onward; clears or shifts its count for the report
module pdh_bin_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [pdh_pkg::RW-1:0] bin_width,
    input  wire logic [pdh_pkg::HW-1:0] my_bin,
    input  wire pdh_pkg::bin_tok_t      tok_in,
    output pdh_pkg::bin_tok_t           tok_out,
    input  wire logic                   clear,
    input  wire logic                   shift,
    input  wire logic [20:0]            cnt_in,
    output logic [20:0]                 cnt
);
    logic hit;
    always_comb
        hit = tok_in.valid && tok_in.in_range && (tok_in.rem < bin_width);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt <= '0;
            tok_out <= '0;
        end
        else
        begin
            tok_out.valid <= tok_in.valid && !hit && tok_in.in_range;
            tok_out.in_range <= tok_in.in_range;
            tok_out.rem <= tok_in.rem - bin_width;
            tok_out.bin <= my_bin;
            if (clear)
                cnt <= '0;
            else if (shift)
                cnt <= cnt_in;
            else if (hit && cnt < pdh_pkg::COUNT_MAX)
                cnt <= cnt + 21'd1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pair_distance_histogram.sv =====
`default_nettype none
// channel    | signals                                   | dir
// request    | start, req_type pos_x/y/z residue; busy    | in; busy out
// result     | out_valid, bin_index pair_count last      | out
// config     | cfg_we cfg_index cfg_data                 | in
// A load writes one atom when accepted. End of frame walks count_a*count_b
// pairs, one per cycle from the two atom memories, through a 19-cell sqrt
// chain and a NUM_BINS-cell bin chain; a drain follows, then the report,
// one result per bin. The last result shows in the cycle that busy drops.
// Reset is asynchronous; counts and histogram clear; atom memories are not.
// Results come one per cycle and cannot be stalled.
module pair_distance_histogram (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  req_type,
    input  wire logic [17:0] pos_x,
    input  wire logic [17:0] pos_y,
    input  wire logic [17:0] pos_z,
    input  wire logic [16:0] residue,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [17:0] cfg_data,
    output logic             out_valid,
    output logic [5:0]       bin_index,
    output logic [20:0]      pair_count,
    output logic             last
);
    localparam int NB = pdh_pkg::NUM_BINS;
    localparam int SQW = pdh_pkg::SQW;
    localparam int RW = pdh_pkg::RW;
    localparam int LAT = pdh_pkg::SQRT_STEPS + NB + 8;

    logic [17:0] box_x_reg, box_y_reg, box_z_reg, bin_w_reg, cutoff_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg <= 18'd4096;
            box_y_reg <= 18'd4096;
            box_z_reg <= 18'd4096;
            bin_w_reg <= 18'd32;
            cutoff_reg <= 18'd1945;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdh_pkg::REG_BOX_X:  box_x_reg <= cfg_data;
                pdh_pkg::REG_BOX_Y:  box_y_reg <= cfg_data;
                pdh_pkg::REG_BOX_Z:  box_z_reg <= cfg_data;
                pdh_pkg::REG_BIN_W:  bin_w_reg <= cfg_data;
                pdh_pkg::REG_CUTOFF: cutoff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [53:0] coords_a [pdh_pkg::MAX_ATOMS_A];
    logic [16:0] labels_a [pdh_pkg::MAX_ATOMS_A];
    logic [53:0] coords_b [pdh_pkg::MAX_ATOMS_B];
    logic [16:0] labels_b [pdh_pkg::MAX_ATOMS_B];
    logic [pdh_pkg::CAW-1:0] count_a_reg, count_a_next;
    logic [pdh_pkg::CBW-1:0] count_b_reg, count_b_next;
    logic [pdh_pkg::CAW-1:0] ia_reg, ia_next;
    logic [pdh_pkg::CBW-1:0] jb_reg, jb_next;
    logic [15:0] drain_reg, drain_next;
    logic [pdh_pkg::HW:0] rep_reg, rep_next;
    pdh_pkg::state_t state_reg, state_next;
    logic accept, load_a, load_b, pair_issue;

    assign accept = start && !busy;
    assign load_a = accept && req_type == pdh_pkg::REQ_LOAD_A
                    && count_a_reg < pdh_pkg::CAW'(pdh_pkg::MAX_ATOMS_A);
    assign load_b = accept && req_type == pdh_pkg::REQ_LOAD_B
                    && count_b_reg < pdh_pkg::CBW'(pdh_pkg::MAX_ATOMS_B);

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            coords_a[count_a_reg[pdh_pkg::AW-1:0]] <= {pos_x, pos_y, pos_z};
            labels_a[count_a_reg[pdh_pkg::AW-1:0]] <= residue;
        end
        if (load_b)
        begin
            coords_b[count_b_reg[pdh_pkg::BW-1:0]] <= {pos_x, pos_y, pos_z};
            labels_b[count_b_reg[pdh_pkg::BW-1:0]] <= residue;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ia_next = ia_reg;
        jb_next = jb_reg;
        drain_next = drain_reg;
        rep_next = rep_reg;
        count_a_next = count_a_reg + pdh_pkg::CAW'(load_a);
        count_b_next = count_b_reg + pdh_pkg::CBW'(load_b);
        unique case (state_reg)
            pdh_pkg::ST_IDLE:
                if (accept && req_type == pdh_pkg::REQ_END)
                begin
                    ia_next = '0;
                    jb_next = '0;
                    drain_next = '0;
                    state_next = (count_a_reg == '0 || count_b_reg == '0)
                                 ? pdh_pkg::ST_DRAIN : pdh_pkg::ST_PAIRS;
                end
            pdh_pkg::ST_PAIRS:
                if (jb_reg + 1'b1 == count_b_reg)
                begin
                    jb_next = '0;
                    ia_next = ia_reg + 1'b1;
                    if (ia_reg + 1'b1 == count_a_reg)
                        state_next = pdh_pkg::ST_DRAIN;
                end
                else
                    jb_next = jb_reg + 1'b1;
            pdh_pkg::ST_DRAIN:
                if (drain_reg == 16'(LAT))
                begin
                    rep_next = '0;
                    state_next = pdh_pkg::ST_REPORT;
                end
                else
                    drain_next = drain_reg + 16'd1;
            pdh_pkg::ST_REPORT:
            begin
                rep_next = rep_reg + 1'b1;
                if (rep_reg == (pdh_pkg::HW+1)'(NB - 1))
                begin
                    state_next = pdh_pkg::ST_IDLE;
                    count_a_next = '0;
                    count_b_next = '0;
                end
            end
            default: state_next = pdh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = state_reg != pdh_pkg::ST_IDLE;
        pair_issue = state_reg == pdh_pkg::ST_PAIRS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdh_pkg::ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            ia_reg <= '0;
            jb_reg <= '0;
            drain_reg <= '0;
            rep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ia_reg <= ia_next;
            jb_reg <= jb_next;
            drain_reg <= drain_next;
            rep_reg <= rep_next;
        end
    end

    // stage 1: memory read
    logic [53:0] ca_r, cb_r;
    logic [16:0] la_r, lb_r;
    logic v1_reg;
    always_ff @(posedge clk)
    begin
        ca_r <= coords_a[ia_reg[pdh_pkg::AW-1:0]];
        la_r <= labels_a[ia_reg[pdh_pkg::AW-1:0]];
        cb_r <= coords_b[jb_reg[pdh_pkg::BW-1:0]];
        lb_r <= labels_b[jb_reg[pdh_pkg::BW-1:0]];
    end

    // stage 2 onward: abs differences, box wrap, squares, sum; same-label pairs dropped
    function automatic logic [17:0] absd(input logic [17:0] a, input logic [17:0] b);
        absd = (a > b) ? a - b : b - a;
    endfunction
    function automatic logic [17:0] wrap(input logic [17:0] d, input logic [17:0] box);
        logic [18:0] d2;
        d2 = {d, 1'b0};
        if (d2 > {1'b0, box})
            wrap = (box > d) ? box - d : d - box;
        else
            wrap = d;
    endfunction
    logic [17:0] dx_r, dy_r, dz_r, gx_r, gy_r, gz_r;
    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic [35:0] sx_r, sy_r, sz_r;
    logic [SQW-1:0] sum_r;
    logic ok2, ok3, ok4;
    always_ff @(posedge clk)
    begin
        dx_r <= absd(ca_r[53:36], cb_r[53:36]);
        dy_r <= absd(ca_r[35:18], cb_r[35:18]);
        dz_r <= absd(ca_r[17:0], cb_r[17:0]);
        ok2 <= la_r != lb_r;
        gx_r <= wrap(dx_r, box_x_reg);
        gy_r <= wrap(dy_r, box_y_reg);
        gz_r <= wrap(dz_r, box_z_reg);
        ok3 <= ok2;
        sx_r <= gx_r * gx_r;
        sy_r <= gy_r * gy_r;
        sz_r <= gz_r * gz_r;
        ok4 <= ok3;
        sum_r <= SQW'(sx_r) + SQW'(sy_r) + SQW'(sz_r);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= pair_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg && ok4;
        end
    end

    // sqrt chain (value width is already even, no padding)
    logic              sv  [pdh_pkg::SQRT_STEPS+1];
    logic [SQW-1:0]    svv [pdh_pkg::SQRT_STEPS+1];
    logic [RW-1:0]     sr  [pdh_pkg::SQRT_STEPS+1];
    logic [SQW+1:0]    srm [pdh_pkg::SQRT_STEPS+1];
    assign sv[0] = v5_reg;
    assign svv[0] = sum_r;
    assign sr[0] = '0;
    assign srm[0] = '0;
    for (genvar k = 0; k < pdh_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        pdh_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(sv[k]), .in_v(svv[k]), .in_root(sr[k]), .in_rem(srm[k]),
            .out_valid(sv[k+1]), .out_v(svv[k+1]), .out_root(sr[k+1]),
            .out_rem(srm[k+1])
        );
    end

    // cutoff check
    pdh_pkg::bin_tok_t tok [NB+1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok[0] <= '0;
        else
        begin
            tok[0].valid <= sv[pdh_pkg::SQRT_STEPS];
            tok[0].rem <= sr[pdh_pkg::SQRT_STEPS];
            tok[0].bin <= '0;
            tok[0].in_range <= ({1'b0, sr[pdh_pkg::SQRT_STEPS]} < {2'b0, cutoff_reg})
                               && bin_w_reg != '0;
        end
    end

    logic [20:0] cnt [NB+1];
    logic clear_h, shift_h;
    assign cnt[NB] = '0;
    assign shift_h = state_reg == pdh_pkg::ST_REPORT;
    assign clear_h = 1'b0;
    for (genvar b = 0; b < NB; b++)
    begin : g_bin
        pdh_bin_cell u_bin (
            .clk(clk), .rst_n(rst_n),
            .bin_width({1'b0, bin_w_reg}),
            .my_bin(pdh_pkg::HW'(b)),
            .tok_in(tok[b]), .tok_out(tok[b+1]),
            .clear(clear_h), .shift(shift_h),
            .cnt_in(cnt[b+1]), .cnt(cnt[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
            bin_index <= '0;
            pair_count <= '0;
            last <= 1'b0;
        end
        else
        begin
            out_valid <= shift_h;
            bin_index <= 6'(rep_reg);
            pair_count <= cnt[0];
            last <= shift_h && rep_reg == (pdh_pkg::HW+1)'(NB - 1);
        end
    end
endmodule
`default_nettype wire
